FILE: rtl/core/sspq_pkg.sv
// Shared types, widths and codes for the stable sorted priority queue.
package sspq_pkg;

  // Default number of entries held by the queue.
  localparam int DEPTH_DEF = 16;

  // Field widths fixed by the interface.
  localparam int DATA_W   = 32;
  localparam int PRIO_W   = 16;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] STS_REMOVED   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd3;

  // Request function codes.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Command from the controller to the datapath for one request.
  typedef struct packed {
    logic                ld;      // capture a result this cycle
    logic                ins;     // insert the incoming entry
    logic                rem;     // remove the head entry
    logic [STATUS_W-1:0] status;  // status to report
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } flags_t;

endpackage

FILE: rtl/core/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue.
//
// A request (insert or remove) is taken at every clock edge where start is
// high and busy is low; busy is high only while rst_n is asserted. For each
// request, the entry cells compare the new priority against every held
// entry at once and shift in the same cycle, so a new request can follow
// every cycle. Its result appears on the out_ ports in the next cycle,
// marked by out_valid for exactly that one cycle; the receiver cannot stall,
// so the result must be captured then. Equal priorities leave in arrival
// order. An insert into a full queue reports overflow, a removal from an
// empty queue reports underflow, and neither changes the queue.
module stable_sorted_priority_queue #(
  parameter int DEPTH = sspq_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_func,
  input  logic signed [sspq_pkg::DATA_W-1:0]   in_data_in,
  input  logic        [sspq_pkg::PRIO_W-1:0]   in_prio_in,
  output logic                                 out_valid,
  output logic        [sspq_pkg::STATUS_W-1:0] out_status,
  output logic signed [sspq_pkg::DATA_W-1:0]   out_data_out,
  output logic        [sspq_pkg::PRIO_W-1:0]   out_prio_out,
  output logic        [sspq_pkg::FILL_W-1:0]   out_fill_count
);

  sspq_pkg::cmd_t   cmd;
  sspq_pkg::flags_t flags;

  // Request decode and result strobe.
  sspq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .flags     (flags),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Entry cells, count and result registers.
  sspq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_data_in     (in_data_in),
    .in_prio_in     (in_prio_in),
    .flags          (flags),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_prio_out   (out_prio_out),
    .out_fill_count (out_fill_count)
  );

endmodule

FILE: rtl/core/sspq_ctrl.sv
// Controller: decodes requests into datapath commands and drives the result strobe.
module sspq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_func,
  input  sspq_pkg::flags_t  flags,
  output sspq_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              out_valid
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  // The queue takes a request every cycle; it only holds off while in reset.
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // Decode the request against the current fill state.
  always_comb begin
    cmd     = '0;
    cmd.ld  = accept;
    if (in_func == sspq_pkg::FUNC_INSERT) begin
      cmd.ins    = accept & ~flags.full;
      cmd.status = flags.full ? sspq_pkg::STS_OVERFLOW : sspq_pkg::STS_INSERTED;
    end else begin
      cmd.rem    = accept & ~flags.empty;
      cmd.status = flags.empty ? sspq_pkg::STS_UNDERFLOW : sspq_pkg::STS_REMOVED;
    end
  end

  // The response state follows every accepted request.
  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = accept ? ST_RESP : ST_IDLE;
      ST_RESP: state_nxt = accept ? ST_RESP : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_valid = (state_r == ST_RESP);

endmodule

FILE: rtl/core/sspq_datapath.sv
// Datapath: a row of sorted entry cells with parallel compare, the count and result registers.
module sspq_datapath #(
  parameter int DEPTH = sspq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sspq_pkg::cmd_t                      cmd,
  input  logic signed [sspq_pkg::DATA_W-1:0]  in_data_in,
  input  logic        [sspq_pkg::PRIO_W-1:0]  in_prio_in,
  output sspq_pkg::flags_t                    flags,
  output logic        [sspq_pkg::STATUS_W-1:0] out_status,
  output logic signed [sspq_pkg::DATA_W-1:0]  out_data_out,
  output logic        [sspq_pkg::PRIO_W-1:0]  out_prio_out,
  output logic        [sspq_pkg::FILL_W-1:0]  out_fill_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [sspq_pkg::DATA_W-1:0] data_r   [DEPTH];
  logic [sspq_pkg::PRIO_W-1:0] prio_r   [DEPTH];
  logic [sspq_pkg::DATA_W-1:0] data_nxt [DEPTH];
  logic [sspq_pkg::PRIO_W-1:0] prio_nxt [DEPTH];
  logic [DEPTH-1:0]            behind;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;

  assign flags.empty = (count_r == '0);
  assign flags.full  = (count_r == CNT_W'(DEPTH));

  // Each cell flags whether the new entry goes at or ahead of it. Empty cells
  // count as flagged, so the flags form one run up to the end of the row.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      behind[i] = (CNT_W'(i) >= count_r) || (prio_r[i] > in_prio_in);
    end
  end

  // Each cell keeps, loads the new entry, shifts back or shifts forward.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      data_nxt[i] = data_r[i];
      prio_nxt[i] = prio_r[i];
      if (cmd.ins && behind[i]) begin
        if (i == 0 || !behind[(i == 0) ? 0 : i-1]) begin
          data_nxt[i] = in_data_in;
          prio_nxt[i] = in_prio_in;
        end else begin
          data_nxt[i] = data_r[(i == 0) ? 0 : i-1];
          prio_nxt[i] = prio_r[(i == 0) ? 0 : i-1];
        end
      end else if (cmd.rem && i < DEPTH-1) begin
        data_nxt[i] = data_r[(i < DEPTH-1) ? i+1 : i];
        prio_nxt[i] = prio_r[(i < DEPTH-1) ? i+1 : i];
      end
    end
  end

  // Entry count after the request.
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Entry cells hold payload only and need no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      data_r[i] <= data_nxt[i];
      prio_r[i] <= prio_nxt[i];
    end
  end

  // Result registers, loaded once per accepted request.
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      out_status     <= cmd.status;
      out_data_out   <= cmd.rem ? data_r[0] : '0;
      out_prio_out   <= cmd.rem ? prio_r[0] : '0;
      out_fill_count <= sspq_pkg::FILL_W'(count_nxt);
    end
  end

endmodule

FILE: rtl/core/sspq_checker.sv
// Port-level checker for the stable sorted priority queue, bound to the top level.
module sspq_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 out_valid,
  input logic        [sspq_pkg::STATUS_W-1:0] out_status,
  input logic signed [sspq_pkg::DATA_W-1:0]   out_data_out,
  input logic        [sspq_pkg::PRIO_W-1:0]   out_prio_out,
  input logic        [sspq_pkg::FILL_W-1:0]   out_fill_count
);

  // Every accepted request yields a result in the next cycle.
  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted request produced no result");

  // No result appears without a request accepted just before.
  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result strobe without an accepted request");

  // Underflow is only reported on an empty queue.
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sspq_pkg::STS_UNDERFLOW) |-> (out_fill_count == '0))
    else $error("underflow reported with entries held");

  // Only a removal carries a data word and priority.
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != sspq_pkg::STS_REMOVED)
      |-> (out_data_out == '0 && out_prio_out == '0))
    else $error("non-removal result carries payload");

endmodule

bind stable_sorted_priority_queue sspq_checker u_sspq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_data_out   (out_data_out),
  .out_prio_out   (out_prio_out),
  .out_fill_count (out_fill_count)
);
